[design/rld_pkg.sv]
// shared widths, codes and constants of the run-length decode iterator
package rld_pkg;

    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int DATA_W = 32;

    typedef logic [OP_W-1:0]   t_opcode;
    typedef logic [ST_W-1:0]   t_status;
    typedef logic [DATA_W-1:0] t_data;

    localparam t_opcode OP_APPEND  = 2'd0;
    localparam t_opcode OP_CONSUME = 2'd1;
    localparam t_opcode OP_CLEAR   = 2'd2;
    // spare code, answered with ok and zero
    localparam t_opcode OP_UNUSED  = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EXHAUSTED = 2'd1;
    localparam t_status ST_FULL      = 2'd2;

    // value reported with an exhausted result
    localparam t_data VALUE_NONE = 32'hFFFF_FFFF;

endpackage

[design/rld_if.sv]
// valid/ready channel interfaces for request and result beats
interface rld_in_if;
    logic                  valid;
    logic                  ready;
    rld_pkg::t_opcode      opcode;
    logic [31:0]           run_count;
    logic signed [31:0]    run_value;
    logic [31:0]           consume_count;

    modport source (output valid, opcode, run_count, run_value, consume_count, input ready);
    modport sink   (input valid, opcode, run_count, run_value, consume_count, output ready);
endinterface

interface rld_out_if;
    logic                  valid;
    logic                  ready;
    rld_pkg::t_status      status;
    logic signed [31:0]    value;

    modport source (output valid, status, value, input ready);
    modport sink   (input valid, status, value, output ready);
endinterface

[design/rld_ram.sv]
// generic single-write, single-read ram with registered read data
module rld_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/run_length_decode_iterator.sv]
// run-length decode iterator: run table in ram, consume walks runs one per cycle
// append, clear and unused opcodes give their result in the cycle after the beat; a consume
// walks until its request is met or the table runs out; throughput: one beat per cycle for
// append/clear while the output is not stalled, none during a walk; the walk pace is set by
// the single read port of the count ram (one run read, updated and written per cycle)
// sync reset: position, run count and output valid clear; table contents stay undefined
module run_length_decode_iterator #(
    parameter int MAX_RUNS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rld_in_if.sink           i_in,
    rld_out_if.source        o_out
);

    localparam int IDX_W = $clog2(MAX_RUNS);
    localparam int POS_W = $clog2(MAX_RUNS + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [POS_W-1:0]      r_loaded, n_loaded;
    logic [31:0]           r_need, n_need;
    logic                  r_out_valid, n_out_valid;
    rld_pkg::t_status      r_status, n_status;
    rld_pkg::t_data        r_value, n_value;

    logic                  in_beat;
    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_waddr;
    logic [31:0]           cnt_wdata;
    logic                  val_we;
    logic [IDX_W-1:0]      raddr;
    logic [31:0]           cnt_rdata;
    rld_pkg::t_data        val_rdata;
    logic [POS_W-1:0]      pos_inc;

    assign i_in.ready  = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign in_beat     = i_in.valid && i_in.ready;
    assign pos_inc     = r_pos + POS_W'(1);
    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_status;
    assign o_out.value  = r_value;

    rld_ram #(.WIDTH(32), .DEPTH(MAX_RUNS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (raddr),
        .o_rdata (cnt_rdata)
    );

    rld_ram #(.WIDTH(rld_pkg::DATA_W), .DEPTH(MAX_RUNS)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (r_loaded[IDX_W-1:0]),
        .i_wdata (rld_pkg::t_data'(i_in.run_value)),
        .i_raddr (raddr),
        .o_rdata (val_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_loaded    = r_loaded;
        n_need      = r_need;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_value     = r_value;
        cnt_we      = 1'b0;
        cnt_waddr   = r_pos[IDX_W-1:0];
        cnt_wdata   = i_in.run_count;
        val_we      = 1'b0;
        raddr       = r_pos[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_status = rld_pkg::ST_OK;
                    n_value  = '0;
                    unique case (i_in.opcode)
                        rld_pkg::OP_APPEND: begin
                            n_out_valid = 1'b1;
                            if (r_loaded != POS_W'(MAX_RUNS)) begin
                                cnt_we    = 1'b1;
                                cnt_waddr = r_loaded[IDX_W-1:0];
                                val_we    = 1'b1;
                                n_loaded  = r_loaded + POS_W'(1);
                            end else begin
                                n_status = rld_pkg::ST_FULL;
                            end
                        end
                        rld_pkg::OP_CONSUME: begin
                            // read of the current run already issued this cycle
                            n_need  = i_in.consume_count;
                            n_state = S_EVAL;
                        end
                        rld_pkg::OP_CLEAR: begin
                            n_out_valid = 1'b1;
                            n_loaded    = '0;
                            n_pos       = '0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_EVAL: begin
                if (r_pos >= r_loaded) begin
                    n_out_valid = 1'b1;
                    n_status    = rld_pkg::ST_EXHAUSTED;
                    n_value     = rld_pkg::VALUE_NONE;
                    n_state     = S_IDLE;
                end else if (r_need == '0) begin
                    n_out_valid = 1'b1;
                    n_status    = rld_pkg::ST_OK;
                    n_value     = val_rdata;
                    n_state     = S_IDLE;
                end else if (cnt_rdata >= r_need) begin
                    cnt_we      = 1'b1;
                    cnt_wdata   = cnt_rdata - r_need;
                    if (cnt_rdata == r_need) begin
                        n_pos = pos_inc;
                    end
                    n_out_valid = 1'b1;
                    n_status    = rld_pkg::ST_OK;
                    n_value     = val_rdata;
                    n_state     = S_IDLE;
                end else begin
                    // run used up: write back zero and read the next run
                    cnt_we    = 1'b1;
                    cnt_wdata = '0;
                    n_need    = r_need - cnt_rdata;
                    n_pos     = pos_inc;
                    raddr     = pos_inc[IDX_W-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_loaded    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_loaded    <= n_loaded;
            r_out_valid <= n_out_valid;
        end
        r_need   <= n_need;
        r_status <= n_status;
        r_value  <= n_value;
    end

    a_pos_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_loaded)
        else $error("read position beyond loaded runs");

    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= POS_W'(MAX_RUNS))
        else $error("run count beyond table size");

    a_walk_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EVAL |-> !r_out_valid)
        else $error("result pending during a walk");

    a_walk_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && cnt_we) |=> $past(r_pos) <= r_pos)
        else $error("walk moved position backward");

endmodule
